// ===== src/csc_pkg.sv =====
package csc_pkg;

  // Scanner mode codes
  localparam logic [2:0] ModePlain     = 3'd0;
  localparam logic [2:0] ModeSlash     = 3'd1;
  localparam logic [2:0] ModeLine      = 3'd2;
  localparam logic [2:0] ModeBlock     = 3'd3;
  localparam logic [2:0] ModeBlockStar = 3'd4;
  localparam logic [2:0] ModeQuote     = 3'd5;
  localparam logic [2:0] ModeQuoteEsc  = 3'd6;

  // Quote kinds
  localparam logic QuoteDouble = 1'b0;
  localparam logic QuoteSingle = 1'b1;

  // Character codes
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5C;

  // Queue between scanner and output stage
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // One queued request: one or two kept bytes from a single input byte
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
  } csc_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } csc_qstat_t;

endpackage

// ===== src/csc_front.sv =====
module csc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] char_in
  input  logic                s_axis_tlast,   // text_end
  input  csc_pkg::csc_qstat_t qstat_i,
  output logic                push_o,
  output csc_pkg::csc_entry_t push_entry_o
);

  logic [2:0] mode_q, mode_d;
  logic       quote_q, quote_d;
  logic [1:0] n;
  logic [7:0] b0, b1;
  logic [7:0] c;
  logic [7:0] q_char;
  logic       accept;

  assign c      = s_axis_tdata;
  assign q_char = quote_q ? csc_pkg::ChSquote : csc_pkg::ChDquote;

  // Accept whenever the queue has room
  assign s_axis_tready = ~qstat_i.full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Classify one byte and pick the kept bytes
  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    n       = 2'd0;
    b0      = c;
    b1      = c;
    case (mode_q)
      csc_pkg::ModeSlash: begin
        if (c == csc_pkg::ChSlash) begin
          mode_d = csc_pkg::ModeLine;
        end else if (c == csc_pkg::ChStar) begin
          mode_d = csc_pkg::ModeBlock;
        end else begin
          // release the held slash, then treat the byte as plain text
          n  = 2'd2;
          b0 = csc_pkg::ChSlash;
          b1 = c;
          if (c == csc_pkg::ChDquote || c == csc_pkg::ChSquote) begin
            quote_d = (c == csc_pkg::ChSquote) ? csc_pkg::QuoteSingle : csc_pkg::QuoteDouble;
            mode_d  = csc_pkg::ModeQuote;
          end else begin
            mode_d = csc_pkg::ModePlain;
          end
        end
      end
      csc_pkg::ModeLine: begin
        if (c == csc_pkg::ChNewline) begin
          n      = 2'd1;
          mode_d = csc_pkg::ModePlain;
        end
      end
      csc_pkg::ModeBlock: begin
        if (c == csc_pkg::ChStar) begin
          mode_d = csc_pkg::ModeBlockStar;
        end else if (c == csc_pkg::ChNewline) begin
          n = 2'd1;
        end
      end
      csc_pkg::ModeBlockStar: begin
        if (c == csc_pkg::ChSlash) begin
          mode_d = csc_pkg::ModePlain;
        end else if (c != csc_pkg::ChStar) begin
          if (c == csc_pkg::ChNewline) begin
            n = 2'd1;
          end
          mode_d = csc_pkg::ModeBlock;
        end
      end
      csc_pkg::ModeQuote: begin
        n = 2'd1;
        if (c == csc_pkg::ChBackslash) begin
          mode_d = csc_pkg::ModeQuoteEsc;
        end else if (c == q_char) begin
          mode_d = csc_pkg::ModePlain;
        end
      end
      csc_pkg::ModeQuoteEsc: begin
        n      = 2'd1;
        mode_d = csc_pkg::ModeQuote;
      end
      default: begin
        // plain text, also the unused code
        if (c == csc_pkg::ChSlash) begin
          mode_d = csc_pkg::ModeSlash;
        end else if (c == csc_pkg::ChDquote || c == csc_pkg::ChSquote) begin
          n       = 2'd1;
          quote_d = (c == csc_pkg::ChSquote) ? csc_pkg::QuoteSingle : csc_pkg::QuoteDouble;
          mode_d  = csc_pkg::ModeQuote;
        end else begin
          n      = 2'd1;
          mode_d = csc_pkg::ModePlain;
        end
      end
    endcase

    // End of text: flush a held slash and return to plain text with the double quote kind
    if (s_axis_tlast) begin
      if (mode_d == csc_pkg::ModeSlash) begin
        if (n == 2'd0) begin
          b0 = csc_pkg::ChSlash;
        end else begin
          b1 = csc_pkg::ChSlash;
        end
        n = n + 2'd1;
      end
      mode_d  = csc_pkg::ModePlain;
      quote_d = csc_pkg::QuoteDouble;
    end
  end

  // Push a request only when the byte keeps something
  assign push_o             = accept & (n != 2'd0);
  assign push_entry_o.byte0 = b0;
  assign push_entry_o.byte1 = b1;
  assign push_entry_o.two   = (n == 2'd2);

  // Advance scanner state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= csc_pkg::ModePlain;
      quote_q <= csc_pkg::QuoteDouble;
    end else if (accept) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
    end
  end

endmodule

// ===== src/csc_queue.sv =====
module csc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csc_pkg::csc_entry_t push_entry_i,
  input  logic                pop_i,
  output csc_pkg::csc_entry_t head_o,
  output csc_pkg::csc_qstat_t qstat_o
);

  csc_pkg::csc_entry_t                mem_q [csc_pkg::QueueDepth];
  logic [csc_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [csc_pkg::QueueCntW-1:0]      cnt_q;

  assign qstat_o.full  = (cnt_q == csc_pkg::QueueCntW'(csc_pkg::QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= csc_pkg::QueueCntW'(csc_pkg::QueueDepth))
    else $error("queue count out of range");

endmodule

// ===== src/csc_back.sv =====
module csc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csc_pkg::csc_entry_t head_i,
  input  csc_pkg::csc_qstat_t qstat_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] char_out
  output logic                m_axis_tlast    // run_last
);

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       pend_valid_q;
  logic [7:0] pend_byte_q;
  logic       load;

  // Output slot is free for new data
  assign load  = !out_valid_q || m_axis_tready;
  assign pop_o = load && !pend_valid_q && !qstat_i.empty;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // Hold control of the output register and second byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (load) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (!qstat_i.empty) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= head_i.two;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load result bytes
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_valid_q) begin
        out_byte_q <= pend_byte_q;
        out_last_q <= 1'b1;
      end else if (!qstat_i.empty) begin
        out_byte_q  <= head_i.byte0;
        out_last_q  <= !head_i.two;
        pend_byte_q <= head_i.byte1;
      end
    end
  end

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("second byte pending without a first");

  a_first_has_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> pend_valid_q)
    else $error("non-last result without a follower");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && out_valid_q && m_axis_tready) |=> (out_valid_q && out_last_q))
    else $error("second byte not shown after first");

endmodule

// ===== src/c_comment_stripper_core.sv =====
// A kept byte is written into the request queue when its input is accepted, then loaded into
// the output register once that register is free, which presents it on the master side.
// Throughput: one input byte per cycle while the queue has room; the output register drains
// one byte per cycle while m_axis_tready is high, so an input that keeps two bytes (released
// slash) needs two transfers. A 4-entry queue between scanner and output stage absorbs bursts.
// Reset (rst_ni low, asynchronous): scanner to plain text, double quote, queue and output empty.
module c_comment_stripper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,   // text_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_out
  output logic       m_axis_tlast    // run_last
);

  logic                push;
  logic                pop;
  csc_pkg::csc_entry_t push_entry;
  csc_pkg::csc_entry_t head;
  csc_pkg::csc_qstat_t qstat;

  csc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .qstat_i      (qstat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  csc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  csc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
